// ===== src/csa_pkg.sv =====
`timescale 1ns / 1ps

package csa_pkg;

   localparam int SLOTS      = 8;
   localparam int OWNER_BITS = 8;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   localparam int KIND_W   = 1;
   localparam int OWNER_W  = 8;
   localparam int LEN_W    = 4;
   localparam int STATUS_W = 2;
   localparam int START_W  = 3;
   localparam int FREED_W  = 4;

   localparam logic [KIND_W-1:0] KIND_RESERVE = 1'b0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] RSP_GRANTED    = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_NO_ROOM    = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_RELEASED   = 2'd2;
   localparam logic [STATUS_W-1:0] RSP_BAD_LENGTH = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [OWNER_W-1:0] owner;
      logic [LEN_W-1:0]   run_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  start_slot;
      logic [FREED_W-1:0]  freed_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

// ===== src/csa_dp.sv =====
`timescale 1ns / 1ps

module csa_dp import csa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  req_type      req_data,
   output rsp_type      rsp_data
);

   req_type                 req_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic [SLOTS-1:0]        used_ff;
   logic [SLOTS-1:0]        used_in;
   logic [OWNER_BITS-1:0]   owner_ff [SLOTS];

   logic [OWNER_BITS-1:0]   who;
   logic                    len_ok;
   logic [SLOTS:0]          full_mask;
   logic [SLOTS-1:0]        run_mask;
   logic [SLOTS-1:0]        fit;
   logic                    found;
   logic [SLOT_W-1:0]       start_idx;
   logic [SLOTS-1:0]        grant_mask;
   logic [SLOTS-1:0]        match;
   logic [CNT_W-1:0]        match_cnt;
   logic                    do_grant;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // tags are written with the used bit, never read before that
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (cmd.execute && do_grant && grant_mask[i]) begin
            owner_ff[i] <= who;
         end
      end
   end

   assign who       = OWNER_BITS'(req_ff.owner);
   assign len_ok    = (req_ff.run_length != '0) && (int'(req_ff.run_length) <= SLOTS);
   assign full_mask = ((SLOTS + 1)'(1) << req_ff.run_length) - (SLOTS + 1)'(1);
   assign run_mask  = full_mask[SLOTS-1:0];

   // run fits at s when every slot of the window is free and it stays in the row
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         fit[s] = (((used_ff >> s) & run_mask) == '0) &&
                  ((s + int'(req_ff.run_length)) <= SLOTS);
      end
   end

   // lowest fitting start wins
   always_comb begin
      found     = 1'b0;
      start_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (fit[s]) begin
            found     = 1'b1;
            start_idx = SLOT_W'(s);
         end
      end
   end

   assign grant_mask = run_mask << start_idx;

   always_comb begin
      match_cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i]  = used_ff[i] && (owner_ff[i] == who);
         match_cnt = match_cnt + CNT_W'(match[i]);
      end
   end

   assign do_grant = (req_ff.kind == KIND_RESERVE) && len_ok && found;

   always_comb begin
      used_in            = used_ff;
      rsp_in.status      = RSP_RELEASED;
      rsp_in.start_slot  = '0;
      rsp_in.freed_count = '0;
      if (req_ff.kind == KIND_RESERVE) begin
         if (!len_ok) begin
            rsp_in.status = RSP_BAD_LENGTH;
         end else if (!found) begin
            rsp_in.status = RSP_NO_ROOM;
         end else begin
            rsp_in.status     = RSP_GRANTED;
            rsp_in.start_slot = START_W'(start_idx);
            if (cmd.execute) begin
               used_in = used_ff | grant_mask;
            end
         end
      end else begin
         rsp_in.freed_count = FREED_W'(match_cnt);
         if (cmd.execute) begin
            used_in = used_ff & ~match;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/csa_ctrl.sv =====
`timescale 1ns / 1ps

module csa_ctrl import csa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_free;

   // output register can take a new result this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/contiguous_slot_allocator.sv =====
`timescale 1ns / 1ps
// response: the request is captured into the request register, then the execute step does
// the run search, owner compare and slot update together and registers the result into the
// response register; a stalled response holds the execute step
// a new request is not taken until the controller returns to idle after each execute, so
// one request is finished before the next is accepted
// reset clears every used bit (all slots free) and empties the response register;
// owner tags are not reset and are only read behind a set used bit
module contiguous_slot_allocator import csa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;

   csa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   csa_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // a transfer in always moves the controller out of idle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request transfer did not start execution");

   // a new response only appears right after an execute cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without an execute cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != RSP_RELEASED |-> rsp_data.freed_count == '0)
      else $error("freed count set on a reserve response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != RSP_GRANTED |-> rsp_data.start_slot == '0)
      else $error("start slot set on a response that granted nothing");

endmodule
